// ===== sv/tdfa_pkg.sv =====
package tdfa_pkg;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int STATE_W  = 8;
  localparam int INFO_W   = 16;
  localparam int LENGTH_W = 12;
  localparam int POS_W    = 24;

  // Transition RAM: one row per state, one column per character
  localparam int STATE_COUNT = 1 << STATE_W;
  localparam int TRANS_AW    = STATE_W + CHAR_W;
  localparam int TRANS_DEPTH = 1 << TRANS_AW;

  // Stream payload layout
  localparam int CMD_W       = 2;
  localparam int IN_FIELDS_W = CHAR_W + 2 * STATE_W + 1 + INFO_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = INFO_W + LENGTH_W + 2 * POS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_STATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EOF_INFO   = CFG_IDX_W'(1);

  // Decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = CHAR_W'(8'h0A);

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR     = 2'd0,
    CMD_END      = 2'd1,
    CMD_WR_TRANS = 2'd2,
    CMD_WR_INFO  = 2'd3
  } cmd_t;

  // One decoded input item as it sits in the queue
  typedef struct packed {
    cmd_t                cmd;
    logic [CHAR_W-1:0]   ch;
    logic [STATE_W-1:0]  row;
    logic [STATE_W-1:0]  next_state;
    logic                next_valid;
    logic [INFO_W-1:0]   info;
  } item_t;

  // Stored transition entry
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] next_state;
  } trans_entry_t;

  // Status from the back end to the front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Status of the queue seen by the front end
  typedef struct packed {
    logic full;
  } queue_status_t;

endpackage

// ===== sv/tdfa_front.sv =====
module tdfa_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tdfa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [tdfa_pkg::CMD_W-1:0]        s_axis_tuser,
  input  tdfa_pkg::back_status_t            back_status,
  input  tdfa_pkg::queue_status_t           queue_status,
  output logic                              push,
  output tdfa_pkg::item_t                   push_item
);
  import tdfa_pkg::*;

  localparam int ROW_LO  = CHAR_W;
  localparam int NEXT_LO = CHAR_W + STATE_W;
  localparam int NV_BIT  = CHAR_W + 2 * STATE_W;
  localparam int INFO_LO = NV_BIT + 1;

  cmd_t cmd;

  // Classify the item kind
  always_comb begin
    unique case (s_axis_tuser)
      CMD_CHAR:     cmd = CMD_CHAR;
      CMD_END:      cmd = CMD_END;
      CMD_WR_TRANS: cmd = CMD_WR_TRANS;
      default:      cmd = CMD_WR_INFO;
    endcase
  end

  // Unpack the payload fields
  always_comb begin
    push_item.cmd        = cmd;
    push_item.ch         = s_axis_tdata[CHAR_W-1:0];
    push_item.row        = s_axis_tdata[ROW_LO +: STATE_W];
    push_item.next_state = s_axis_tdata[NEXT_LO +: STATE_W];
    push_item.next_valid = s_axis_tdata[NV_BIT];
    // info is only meaningful for state-info writes
    push_item.info       = (cmd == CMD_WR_INFO) ? s_axis_tdata[INFO_LO +: INFO_W] : '0;
  end

  // No transfer while the table is being cleared or the queue is full
  assign s_axis_tready = !back_status.clearing && !queue_status.full;
  assign push          = s_axis_tvalid && s_axis_tready;

endmodule

// ===== sv/tdfa_queue.sv =====
module tdfa_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  tdfa_pkg::item_t          push_item,
  output tdfa_pkg::queue_status_t  status,
  input  logic                     pop,
  output logic                     head_valid,
  output tdfa_pkg::item_t          head_item
);
  import tdfa_pkg::*;

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  assign head_valid  = (count != '0);
  assign head_item   = slots[rd_ptr];
  assign status.full = (count == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== sv/tdfa_back.sv =====
module tdfa_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [tdfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              q_valid,
  input  tdfa_pkg::item_t                   q_item,
  output logic                              q_pop,
  output tdfa_pkg::back_status_t            status,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tdfa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast
);
  import tdfa_pkg::*;

  // Configuration registers
  logic [STATE_W-1:0]  root_state;
  logic [INFO_W-1:0]   eof_info;

  // Memories
  trans_entry_t        trans_mem [TRANS_DEPTH];
  logic [INFO_W-1:0]   info_mem  [STATE_COUNT];
  trans_entry_t        trans_rd;
  logic [INFO_W-1:0]   info_rd;

  // Clear sweep
  logic                clearing;
  logic [TRANS_AW-1:0] clr_addr;

  // Scan state
  logic [STATE_W-1:0]  cur_state;
  logic [LENGTH_W-1:0] length_count;
  logic [POS_W-1:0]    line_count;
  logic [POS_W-1:0]    column_count;

  // Execute stage
  logic                s2_valid;
  cmd_t                s2_cmd;
  logic [CHAR_W-1:0]   s2_ch;

  // Output register payload
  logic [INFO_W-1:0]   out_info;
  logic [LENGTH_W-1:0] out_length;
  logic [POS_W-1:0]    out_line;
  logic [POS_W-1:0]    out_column;
  logic                out_end;

  logic                back_go;
  logic                emit;
  logic [STATE_W-1:0]  state_after;
  logic [STATE_W-1:0]  state_fwd;
  logic [LENGTH_W-1:0] length_inc;
  logic [LENGTH_W-1:0] length_after;
  logic [POS_W-1:0]    line_after;
  logic [POS_W-1:0]    column_after;
  logic [POS_W-1:0]    column_base;
  logic [INFO_W-1:0]   emit_info;
  logic [LENGTH_W-1:0] emit_length;
  logic [TRANS_AW-1:0] trans_addr;
  logic                trans_we;
  logic                lookup;
  logic                info_we;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      root_state <= '0;
      eof_info   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROOT_STATE: root_state <= cfg_data[STATE_W-1:0];
        CFG_EOF_INFO:   eof_info   <= cfg_data[INFO_W-1:0];
        default: ;
      endcase
    end
  end

  // Clear sweep over the transition RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  assign status.clearing = clearing;

  // Whole back end advances when the output register can take a result
  assign back_go = !m_axis_tvalid || m_axis_tready;
  assign q_pop   = back_go && q_valid && !clearing;

  // Execute stage: counters, emit decision and next state
  always_comb begin
    column_base  = (s2_ch == NEWLINE_CHAR) ? '0 : column_count;
    line_after   = line_count;
    column_after = column_count;
    length_inc   = (length_count == '1) ? length_count : length_count + 1'b1;
    length_after = length_count;
    state_after  = cur_state;
    emit         = 1'b0;
    emit_info    = info_rd;
    emit_length  = length_inc;
    case (s2_cmd)
      CMD_CHAR: begin
        if (s2_ch == NEWLINE_CHAR) begin
          line_after = (line_count == '1) ? line_count : line_count + 1'b1;
        end
        column_after = (column_base == '1) ? column_base : column_base + 1'b1;
        if (trans_rd.valid) begin
          state_after  = trans_rd.next_state;
          length_after = length_inc;
        end else begin
          emit         = 1'b1;
          state_after  = root_state;
          length_after = '0;
        end
      end
      CMD_END: begin
        emit         = 1'b1;
        emit_info    = eof_info;
        emit_length  = length_count;
        state_after  = root_state;
        length_after = '0;
      end
      default: ;
    endcase
  end

  // Next-state forwarding into the lookup address
  assign state_fwd = s2_valid ? state_after : cur_state;

  // Issue stage: at most one access to each RAM per item
  assign trans_addr = (q_item.cmd == CMD_WR_TRANS) ? {q_item.row, q_item.ch}
                                                   : {state_fwd, q_item.ch};
  assign trans_we   = q_pop && (q_item.cmd == CMD_WR_TRANS);
  assign lookup     = q_pop && (q_item.cmd == CMD_CHAR);
  assign info_we    = q_pop && (q_item.cmd == CMD_WR_INFO);

  // Transition RAM
  always_ff @(posedge clk) begin
    if (clearing) begin
      trans_mem[clr_addr] <= '0;
    end else if (trans_we) begin
      trans_mem[trans_addr] <= '{valid: q_item.next_valid,
                                 next_state: q_item.next_valid ? q_item.next_state : '0};
    end
    if (lookup) trans_rd <= trans_mem[trans_addr];
  end

  // State info RAM
  always_ff @(posedge clk) begin
    if (info_we) info_mem[q_item.row] <= q_item.info;
    if (lookup)  info_rd <= info_mem[state_fwd];
  end

  // Issue to execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (back_go) begin
      s2_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cmd <= q_item.cmd;
      s2_ch  <= q_item.ch;
    end
  end

  // Scan state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state    <= '0;
      length_count <= '0;
      line_count   <= '0;
      column_count <= '0;
    end else if (back_go && s2_valid) begin
      cur_state    <= state_after;
      length_count <= length_after;
      line_count   <= line_after;
      column_count <= column_after;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (back_go) begin
      m_axis_tvalid <= s2_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (back_go && s2_valid && emit) begin
      out_info   <= emit_info;
      out_length <= emit_length;
      out_line   <= line_after;
      out_column <= column_after;
      out_end    <= (s2_cmd == CMD_END);
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({out_column, out_line, out_length, out_info});
  assign m_axis_tlast = out_end;

endmodule

// ===== sv/table_driven_dfa_scanner.sv =====
// Table-driven DFA scanner. Items enter on the slave stream at one per cycle while s_axis_tready
// is high, and results leave on the master stream, one per token; the sustained rate is one item
// per clock while the output is not stalled, set by the loop from the registered transition RAM
// read through the next-state select back into the RAM address. A character item passes through
// the input queue, then the registered RAM read and execute stage, then the output register
// before its token shows on m_axis_tvalid. While a result is held off, the queue and the execute
// stage keep up to five items before s_axis_tready drops. After reset the transition RAM is
// cleared one entry per cycle, all 65536 entries, during which s_axis_tready stays low;
// configuration writes are taken at any time but should be made only while the block is idle.
// Unwritten state-info entries read as unknown data.
module table_driven_dfa_scanner (
  input  logic                              clk,
  input  logic                              rst,
  // s_axis_tdata: char_byte, table_state, next_state_value, next_valid, info_value, zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tdfa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // s_axis_tuser: command
  input  logic [tdfa_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // m_axis_tdata: token_info, token_length, line_number, column_number, zero pad
  output logic [tdfa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // m_axis_tlast: at_end
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tdfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tdfa_pkg::*;

  back_status_t  back_status;
  queue_status_t queue_status;
  logic          push;
  item_t         push_item;
  logic          head_valid;
  item_t         head_item;
  logic          pop;

  assign cfg_ready = 1'b1;

  tdfa_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .back_status   (back_status),
    .queue_status  (queue_status),
    .push          (push),
    .push_item     (push_item)
  );

  tdfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .status     (queue_status),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tdfa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (head_valid),
    .q_item        (head_item),
    .q_pop         (pop),
    .status        (back_status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== sv/tdfa_checker.sv =====
module tdfa_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tdfa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);
  import tdfa_pkg::*;

  localparam int LEN_LO = INFO_W;
  localparam int COL_LO = INFO_W + LENGTH_W + POS_W;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Input is closed while the transition table is cleared after reset
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input open right after reset");

  // A rejected character is counted in its token
  a_token_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[LEN_LO +: LENGTH_W] != '0)
    else $error("character token with zero length");

  // A character token always leaves the column past zero
  a_token_col: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[COL_LO +: POS_W] != '0)
    else $error("character token with column zero");

endmodule

bind table_driven_dfa_scanner tdfa_checker u_tdfa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
